// ===== rtl/srec_pkg.sv =====
`timescale 1ns / 1ps
// srec_pkg: shared codes, parser state and result types, hex digit helpers
// used by srec_step and srec_record_parser; depends on nothing else

package srec_pkg;

	localparam logic [2:0] PH_WAIT_S = 3'd0;
	localparam logic [2:0] PH_TYPE   = 3'd1;
	localparam logic [2:0] PH_LEN    = 3'd2;
	localparam logic [2:0] PH_ADDR   = 3'd3;
	localparam logic [2:0] PH_DATA   = 3'd4;
	localparam logic [2:0] PH_CHK    = 3'd5;

	localparam logic [1:0] KIND_HEADER  = 2'd0;
	localparam logic [1:0] KIND_DATA32  = 2'd1;
	localparam logic [1:0] KIND_END32   = 2'd2;
	localparam logic [1:0] KIND_UNKNOWN = 2'd3;

	localparam logic [7:0] CHAR_S     = 8'h53;
	localparam logic [7:0] CHAR_0     = 8'h30;
	localparam logic [7:0] CHAR_3     = 8'h33;
	localparam logic [7:0] CHAR_7     = 8'h37;
	localparam logic [7:0] CHAR_9     = 8'h39;
	localparam logic [7:0] CHAR_UPPER = 8'h41;
	localparam logic [7:0] CHAR_LOWER = 8'h61;
	localparam logic [7:0] DIGIT_TEN  = 8'h0a;

	localparam logic [2:0]  ADDR_BYTES = 3'd4;
	localparam logic [15:0] COUNT_MAX  = 16'hffff;

	typedef struct packed {
		logic [2:0]  phase;
		logic        hi_pending;
		logic [3:0]  held;
		logic [7:0]  bytes_left;
		logic [2:0]  addr_left;
		logic [31:0] addr;
		logic [7:0]  sum;
		logic [1:0]  kind;
		logic [15:0] records;
	} parse_state_t;

	typedef struct packed {
		logic        data_valid;
		logic [7:0]  data_byte;
		logic        record_end;
		logic [1:0]  record_kind;
		logic [31:0] record_address;
		logic        checksum_ok;
		logic        extra_data;
		logic [15:0] record_count;
	} parse_result_t;

	// hex mapping taken modulo 16, any character gives a value
	function automatic logic [3:0] hex_value(input logic [6:0] c);
		logic [7:0] cw;
		logic [7:0] v;
		cw = {1'b0, c};
		if (cw > CHAR_9) begin
			if (cw >= CHAR_LOWER)
				v = cw - CHAR_LOWER + DIGIT_TEN;
			else
				v = cw - CHAR_UPPER + DIGIT_TEN;
		end else begin
			v = cw - CHAR_0;
		end
		return v[3:0];
	endfunction

	function automatic logic [7:0] dec_sat(input logic [7:0] x);
		return (x == 8'd0) ? 8'd0 : x - 8'd1;
	endfunction

endpackage

// ===== rtl/srec_record_parser.sv =====
`timescale 1ns / 1ps
// srec_record_parser: top level of the S-record character parser
// depends on srec_pkg and srec_step
//
// Usage
//   Input channel: in_valid / in_ready carry one received character per item
//   on char_code. Output channel: out_valid / out_ready carry one result item
//   for every character: a payload byte of a data record, the end of a record
//   with its checksum verdict, and the current kind, address and record count.
//   A character accepted into the input register has its result loaded into the
//   output register once that register is free, which raises out_valid.
//   Throughput: one character per cycle while results are taken, set by
//   the combinational parser state update between input and output registers.
//   When the receiver stalls, the result stays in the output register and the
//   input register still takes one more character; after that in_ready falls
//   until the output is taken. No item is lost or repeated.
//   Reset (arst_n low) empties both registers and returns the parser to
//   waiting for S with the sum, address and record count cleared.

module srec_record_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_code,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        data_valid,
	output logic [7:0]  data_byte,
	output logic        record_end,
	output logic [1:0]  record_kind,
	output logic [31:0] record_address,
	output logic        checksum_ok,
	output logic        extra_data,
	output logic [15:0] record_count
);
	import srec_pkg::*;

	logic          valid_s1;
	logic [7:0]    char_s1;
	logic          valid_s2;
	parse_result_t res_s2;
	parse_state_t  st_q;
	parse_state_t  st_nx;
	parse_result_t res_nx;
	logic          s2_free;
	logic          adv_s1;

	assign s2_free  = !valid_s2 || out_ready;
	assign adv_s1   = valid_s1 && s2_free;
	assign in_ready = !valid_s1 || s2_free;

	srec_step u_step (
		.st  (st_q),
		.ch  (char_s1),
		.nx  (st_nx),
		.res (res_nx)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			char_s1 <= char_code;
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (adv_s1) begin
			st_q <= st_nx;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1)
			res_s2 <= res_nx;
	end

	assign out_valid      = valid_s2;
	assign data_valid     = res_s2.data_valid;
	assign data_byte      = res_s2.data_byte;
	assign record_end     = res_s2.record_end;
	assign record_kind    = res_s2.record_kind;
	assign record_address = res_s2.record_address;
	assign checksum_ok    = res_s2.checksum_ok;
	assign extra_data     = res_s2.extra_data;
	assign record_count   = res_s2.record_count;

	a_byte_not_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(data_valid && record_end))
		else $error("payload byte and record end in the same item");

	a_ok_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (checksum_ok || extra_data)) |-> record_end)
		else $error("checksum or extra flag outside record end");

	a_extra_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && extra_data) |-> (record_kind == KIND_END32))
		else $error("extra data flagged on a record that is not an end record");

	a_data_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && data_valid) |-> (record_kind == KIND_DATA32))
		else $error("payload byte from a record that is not a data record");

	a_count_mono: assert property (@(posedge clk) disable iff (!arst_n)
		$past(st_q.records) <= st_q.records)
		else $error("record count went backwards");

	a_phase_legal: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.phase <= PH_CHK)
		else $error("parser phase left the used range");

endmodule

// ===== rtl/srec_step.sv =====
`timescale 1ns / 1ps
// srec_step: next parser state and result for one character
// depends on srec_pkg

module srec_step (
	input  srec_pkg::parse_state_t  st,
	input  logic [7:0]              ch,
	output srec_pkg::parse_state_t  nx,
	output srec_pkg::parse_result_t res
);
	import srec_pkg::*;

	logic [7:0] c;
	logic [3:0] nib;
	logic [7:0] b;
	logic [7:0] bl_dec;
	logic [7:0] b_dec;
	logic [2:0] al_dec;
	logic       dvalid;
	logic [7:0] dbyte;
	logic       rend;
	logic       cok;
	logic       extra;

	assign c      = {1'b0, ch[6:0]};
	assign nib    = hex_value(ch[6:0]);
	assign b      = {st.held, nib};
	assign bl_dec = dec_sat(st.bytes_left);
	assign b_dec  = dec_sat(b);
	assign al_dec = st.addr_left - 3'd1;

	always_comb begin
		nx     = st;
		dvalid = 1'b0;
		dbyte  = 8'd0;
		rend   = 1'b0;
		cok    = 1'b0;
		extra  = 1'b0;
		unique case (st.phase)
			PH_TYPE: begin
				unique case (ch)
					CHAR_0:  nx.kind = KIND_HEADER;
					CHAR_3:  nx.kind = KIND_DATA32;
					CHAR_7:  nx.kind = KIND_END32;
					default: nx.kind = KIND_UNKNOWN;
				endcase
				nx.phase = PH_LEN;
			end
			PH_LEN, PH_ADDR, PH_DATA, PH_CHK: begin
				if (!st.hi_pending) begin
					nx.held       = nib;
					nx.hi_pending = 1'b1;
				end else begin
					nx.hi_pending = 1'b0;
					if (st.phase == PH_CHK) begin
						rend     = 1'b1;
						cok      = (b == ~st.sum);
						extra    = (st.kind == KIND_END32) && (st.bytes_left != 8'd0);
						nx.phase = PH_WAIT_S;
					end else begin
						nx.sum = st.sum + b;
						priority if (st.phase == PH_LEN) begin
							nx.bytes_left = b_dec;
							priority if (st.kind == KIND_HEADER) begin
								nx.phase = (b_dec != 8'd0) ? PH_DATA : PH_CHK;
							end else if (st.kind == KIND_UNKNOWN) begin
								nx.phase = PH_CHK;
							end else begin
								nx.addr_left = ADDR_BYTES;
								nx.phase     = PH_ADDR;
							end
						end else if (st.phase == PH_ADDR) begin
							nx.addr       = {st.addr[23:0], b};
							nx.bytes_left = bl_dec;
							nx.addr_left  = al_dec;
							if (al_dec == 3'd0) begin
								if (st.kind == KIND_DATA32 && bl_dec != 8'd0)
									nx.phase = PH_DATA;
								else
									nx.phase = PH_CHK;
							end
						end else begin
							nx.bytes_left = bl_dec;
							if (st.kind == KIND_DATA32) begin
								dvalid = 1'b1;
								dbyte  = b;
							end
							if (bl_dec == 8'd0)
								nx.phase = PH_CHK;
						end
					end
				end
			end
			default: begin
				// waiting for S, and any unused phase code
				nx.phase = PH_WAIT_S;
				if (c == CHAR_S) begin
					if (st.records != COUNT_MAX)
						nx.records = st.records + 16'd1;
					nx.sum        = 8'd0;
					nx.addr       = 32'd0;
					nx.hi_pending = 1'b0;
					nx.held       = 4'd0;
					nx.bytes_left = 8'd0;
					nx.addr_left  = 3'd0;
					nx.phase      = PH_TYPE;
				end
			end
		endcase
	end

	always_comb begin
		res.data_valid     = dvalid;
		res.data_byte      = dbyte;
		res.record_end     = rend;
		res.record_kind    = nx.kind;
		res.record_address = nx.addr;
		res.checksum_ok    = cok;
		res.extra_data     = extra;
		res.record_count   = nx.records;
	end

endmodule

// ===== tb/tb_srec_record_parser.sv =====
`timescale 1ns / 1ps
// tb_srec_record_parser: self-checking bench for the S-record parser, feeding
// directed and random record streams with random idling on both sides
// depends on srec_pkg and srec_record_parser

module tb_srec_record_parser;
	import srec_pkg::*;

	class parse_checker;
		logic [2:0]  phase;
		logic        hi_pending;
		logic [3:0]  held;
		logic [7:0]  left;
		logic [2:0]  addr_left;
		logic [31:0] addr;
		logic [7:0]  sum;
		logic [1:0]  kind;
		logic [15:0] count;
		parse_result_t parse_results_q[$];
		int errors;
		int chars_seen;
		int records_done;
		int good_sums;
		int payload_bytes;

		function new();
			phase = PH_WAIT_S;
			hi_pending = 1'b0;
			held = '0;
			left = '0;
			addr_left = '0;
			addr = '0;
			sum = '0;
			kind = KIND_HEADER;
			count = '0;
			errors = 0;
			chars_seen = 0;
			records_done = 0;
			good_sums = 0;
			payload_bytes = 0;
		endfunction

		function logic [3:0] digit_value(logic [6:0] c);
			logic [7:0] w;
			logic [7:0] v;
			w = {1'b0, c};
			if (w > CHAR_9)
				v = (w >= CHAR_LOWER) ? w - CHAR_LOWER + DIGIT_TEN : w - CHAR_UPPER + DIGIT_TEN;
			else
				v = w - CHAR_0;
			return v[3:0];
		endfunction

		function logic [7:0] step_down(logic [7:0] x);
			return (x == 8'd0) ? 8'd0 : x - 8'd1;
		endfunction

		function int pending();
			return parse_results_q.size();
		endfunction

		function void take_char(logic [7:0] raw);
			logic [6:0] c;
			logic [7:0] b;
			parse_result_t r;
			c = raw[6:0];
			r = '0;
			chars_seen++;
			if (phase == PH_WAIT_S || phase > PH_CHK) begin
				phase = PH_WAIT_S;
				if (c == CHAR_S[6:0]) begin
					if (count != COUNT_MAX)
						count = count + 16'd1;
					sum = '0;
					addr = '0;
					hi_pending = 1'b0;
					held = '0;
					left = '0;
					addr_left = '0;
					phase = PH_TYPE;
				end
			end else if (phase == PH_TYPE) begin
				case (raw)
					CHAR_0: kind = KIND_HEADER;
					CHAR_3: kind = KIND_DATA32;
					CHAR_7: kind = KIND_END32;
					default: kind = KIND_UNKNOWN;
				endcase
				phase = PH_LEN;
			end else if (!hi_pending) begin
				held = digit_value(c);
				hi_pending = 1'b1;
			end else begin
				b = {held, digit_value(c)};
				hi_pending = 1'b0;
				if (phase == PH_CHK) begin
					r.record_end = 1'b1;
					r.checksum_ok = (b == ~sum);
					r.extra_data = (kind == KIND_END32) && (left != 8'd0);
					phase = PH_WAIT_S;
					records_done++;
					if (r.checksum_ok)
						good_sums++;
				end else begin
					sum = sum + b;
					if (phase == PH_LEN) begin
						left = step_down(b);
						if (kind == KIND_HEADER) begin
							phase = (left != 8'd0) ? PH_DATA : PH_CHK;
						end else if (kind == KIND_UNKNOWN) begin
							phase = PH_CHK;
						end else begin
							addr_left = ADDR_BYTES;
							phase = PH_ADDR;
						end
					end else if (phase == PH_ADDR) begin
						addr = {addr[23:0], b};
						left = step_down(left);
						addr_left = addr_left - 3'd1;
						if (addr_left == 3'd0)
							phase = (kind == KIND_DATA32 && left != 8'd0) ? PH_DATA : PH_CHK;
					end else begin
						left = step_down(left);
						if (kind == KIND_DATA32) begin
							r.data_valid = 1'b1;
							r.data_byte = b;
							payload_bytes++;
						end
						if (left == 8'd0)
							phase = PH_CHK;
					end
				end
			end
			r.record_kind = kind;
			r.record_address = addr;
			r.record_count = count;
			parse_results_q.push_back(r);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				errors++;
				$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			end
		endfunction

		function void check_output(parse_result_t got);
			parse_result_t want;
			if (parse_results_q.size() == 0) begin
				errors++;
				$error("result arrived with no character pending");
				return;
			end
			want = parse_results_q.pop_front();
			compare_field("data_valid", 32'(want.data_valid), 32'(got.data_valid));
			compare_field("data_byte", 32'(want.data_byte), 32'(got.data_byte));
			compare_field("record_end", 32'(want.record_end), 32'(got.record_end));
			compare_field("record_kind", 32'(want.record_kind), 32'(got.record_kind));
			compare_field("record_address", want.record_address, got.record_address);
			compare_field("checksum_ok", 32'(want.checksum_ok), 32'(got.checksum_ok));
			compare_field("extra_data", 32'(want.extra_data), 32'(got.extra_data));
			compare_field("record_count", 32'(want.record_count), 32'(got.record_count));
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  char_code;
	logic        out_valid;
	logic        out_ready;
	logic        data_valid;
	logic [7:0]  data_byte;
	logic        record_end;
	logic [1:0]  record_kind;
	logic [31:0] record_address;
	logic        checksum_ok;
	logic        extra_data;
	logic [15:0] record_count;

	parse_checker sb;
	bit tx_idle;
	bit rx_idle;
	int chars_sent;

	srec_record_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.char_code(char_code),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.data_valid(data_valid),
		.data_byte(data_byte),
		.record_end(record_end),
		.record_kind(record_kind),
		.record_address(record_address),
		.checksum_ok(checksum_ok),
		.extra_data(extra_data),
		.record_count(record_count)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic send_char(input logic [7:0] c);
		int gap;
		gap = tx_idle ? $urandom_range(0, 14) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		char_code = c;
		do @(posedge clk); while (!in_ready);
		sb.take_char(c);
		chars_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i]);
	endtask

	function automatic logic [7:0] hex_digit(input logic [3:0] n, input bit lower);
		if (n < 4'd10)
			return CHAR_0 + n;
		return (lower ? CHAR_LOWER : CHAR_UPPER) + n - DIGIT_TEN;
	endfunction

	task automatic send_hex_byte(input logic [7:0] b);
		logic [7:0] ch;
		for (int k = 0; k < 2; k++) begin
			ch = hex_digit(k == 0 ? b[7:4] : b[3:0], 1'($urandom_range(0, 1)));
			if ($urandom_range(0, 29) == 0)
				ch = ch | 8'h80;
			else if ($urandom_range(0, 59) == 0)
				ch = 8'($urandom_range(0, 255));
			send_char(ch);
		end
	endtask

	task automatic send_random_record();
		int sel;
		int n;
		int extra;
		logic [7:0] tch;
		logic [7:0] len;
		logic [7:0] total;
		logic [7:0] chk;
		logic [7:0] body[$];
		sel = $urandom_range(0, 19);
		extra = 0;
		body = {};
		if (sel < 3) begin
			tch = CHAR_0;
			n = ($urandom_range(0, 40) == 0) ? 254 : $urandom_range(0, 12);
		end else if (sel < 14) begin
			tch = CHAR_3;
			n = 4 + $urandom_range(0, 16);
		end else if (sel < 18) begin
			tch = CHAR_7;
			n = 4;
			if ($urandom_range(0, 3) == 0)
				extra = $urandom_range(1, 6);
		end else begin
			n = 0;
			do tch = 8'($urandom_range(0, 255));
			while (tch == CHAR_0 || tch == CHAR_3 || tch == CHAR_7);
		end
		if (tch != CHAR_0 && $urandom_range(0, 29) == 0)
			tch = tch | 8'h80;
		for (int i = 0; i < n; i++)
			body.push_back(8'($urandom_range(0, 255)));
		len = 8'(n + 1 + extra);
		if ($urandom_range(0, 9) == 0)
			len = ($urandom_range(0, 5) == 0) ? 8'hff : 8'($urandom_range(0, 8));
		total = len;
		foreach (body[i])
			total = total + body[i];
		chk = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : ~total;
		send_char(($urandom_range(0, 3) == 0) ? (CHAR_S | 8'h80) : CHAR_S);
		send_char(tch);
		send_hex_byte(len);
		foreach (body[i])
			send_hex_byte(body[i]);
		send_hex_byte(chk);
		repeat (extra) send_hex_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	initial begin
		int stretch;
		int until_pause;
		out_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stretch = rx_idle ? $urandom_range(0, 14) : 0;
			if (stretch > 0) begin
				out_ready = 1'b0;
				repeat (stretch) @(negedge clk);
			end
			out_ready = 1'b1;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_output({data_valid, data_byte, record_end, record_kind, record_address,
				checksum_ok, extra_data, record_count});
	end

	initial begin
		#20_000_000;
		$display("srec_record_parser: mismatch");
		$finish;
	end

	initial begin
		int mode_mark;
		int pause_mark;
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		char_code = 8'h00;
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		chars_sent = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// noise extremes, masked start, type with top bit set, zero length
		send_char(8'h00);
		send_char(8'hff);
		send_char(CHAR_S | 8'h80);
		send_char(CHAR_0 | 8'h80);
		send_text("00FF");
		send_text("S000FF");
		// short length on an end record, non-hex digits in the address
		send_text("S7031g3~5678E7");
		drain();

		mode_mark = chars_sent;
		pause_mark = chars_sent;
		while (chars_sent < 1700) begin
			if (chars_sent - mode_mark >= 150) begin
				tx_idle = ($urandom_range(0, 3) != 0);
				rx_idle = ($urandom_range(0, 3) != 0);
				mode_mark = chars_sent;
			end
			if (chars_sent - pause_mark >= 400) begin
				drain();
				pause_mark = chars_sent;
			end
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 3)) send_char(8'($urandom_range(0, 255)));
			send_random_record();
		end
		drain();

		tx_idle = 1'b1;
		rx_idle = 1'b1;
		send_random_record();
		send_random_record();
		drain();
		repeat (8) @(posedge clk);

		if (sb.pending() != 0)
			$error("%0d expected results never arrived", sb.pending());
		$display("covered %0d characters, %0d finished records (%0d with a good checksum)",
			sb.chars_seen, sb.records_done, sb.good_sums);
		$display("streamed %0d payload bytes, record count ended at %0d",
			sb.payload_bytes, sb.count);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("srec_record_parser: match");
		else
			$display("srec_record_parser: mismatch");
		$finish;
	end

endmodule
